/* hw/rtl/nimh_charge_duty_controller_macros.svh */
// Assertion macros for the NiMH charge duty controller.
// Depends on nothing; the asserting module supplies clk and rst_n by those names.
`ifndef NIMH_CHARGE_DUTY_CONTROLLER_MACROS_SVH
`define NIMH_CHARGE_DUTY_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define NCD_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("nimh_charge_duty_controller: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define NCD_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("nimh_charge_duty_controller: next-cycle check failed");
`else
`define NCD_ASSERT_NOW(label, cond, prop)
`define NCD_ASSERT_NEXT(label, cond, prop)
`endif
`endif

/* hw/rtl/nimhcd_pkg.sv */
// Package for the NiMH charge duty controller: field widths, register
// reset values, register index codes and run status codes. No dependencies.
`default_nettype none
package nimhcd_pkg;

    // Fixed field widths.
    localparam int DUTY_W     = 10;
    localparam int THR_W      = 10;
    localparam int NUM_W      = 18;
    localparam int LIMIT_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Saturation value of the duty.
    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;

    // Register reset values.
    localparam logic [THR_W-1:0]   LOW_THR_RST   = 10'd155;
    localparam logic [THR_W-1:0]   HIGH_THR_RST  = 10'd372;
    localparam logic [THR_W-1:0]   MAX_THR_RST   = 10'd403;
    localparam logic [NUM_W-1:0]   TRICKLE_RST   = 18'd7905;
    localparam logic [NUM_W-1:0]   NORMAL_RST    = 18'd79050;
    localparam logic [LIMIT_W-1:0] MIN_LIMIT_RST = 8'd120;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THR   = 3'd0,
        CFG_HIGH_THR  = 3'd1,
        CFG_MAX_THR   = 3'd2,
        CFG_TRICKLE   = 3'd3,
        CFG_NORMAL    = 3'd4,
        CFG_MIN_LIMIT = 3'd5
    } cfg_reg_t;

    // Run status codes.
    typedef enum logic [STATUS_W-1:0] {
        RUN_CHARGING = 2'd0,
        RUN_STOPPED  = 2'd1,
        RUN_LIMIT    = 2'd2
    } run_status_t;

endpackage
`default_nettype wire

/* hw/rtl/nimh_charge_duty_controller.sv */
// NiMH charge duty controller top level: threshold decision, bit-serial
// restoring divider and output register. Depends on nimhcd_pkg and the macros header.
// A sample that needs a duty quotient passes through the divider, one quotient
// bit per cycle over 18 bits, then the load state, then the output register.
// New samples are stalled until the item is in the output register, which can be
// held by out_stall; LED ticks and samples without a division skip the divider.
// Reset (rst_n low, asynchronous) restores the register defaults, clears duty,
// stage, LED, minute count and status, and empties the output register.
`default_nettype none
`include "nimh_charge_duty_controller_macros.svh"

module nimh_charge_duty_controller
    import nimhcd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // Input channel.
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    // Output channel.
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [DUTY_W-1:0]           duty,
    output logic [BYTE_W-1:0]           duty_high_byte,
    output logic [BYTE_W-1:0]           duty_low_byte,
    output logic                        charge_stage,
    output logic                        led_on,
    output logic [STATUS_W-1:0]         run_status,
    output logic [LIMIT_W-1:0]          minutes_done
);

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    // Configuration registers.
    logic [THR_W-1:0]   low_thr_reg, low_thr_next;
    logic [THR_W-1:0]   high_thr_reg, high_thr_next;
    logic [THR_W-1:0]   max_thr_reg, max_thr_next;
    logic [NUM_W-1:0]   trickle_reg, trickle_next;
    logic [NUM_W-1:0]   normal_reg, normal_next;
    logic [LIMIT_W-1:0] min_limit_reg, min_limit_next;

    // Charge state.
    state_t             state_reg, state_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic               stage_reg, stage_next;
    logic               led_reg, led_next;
    logic [LIMIT_W-1:0] minute_count_reg, minute_count_next;
    run_status_t        status_reg, status_next;

    // Divider.
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]  duty_out_reg, duty_out_next;
    logic               stage_out_reg, stage_out_next;
    logic               led_out_reg, led_out_next;
    run_status_t        status_out_reg, status_out_next;
    logic [LIMIT_W-1:0] minutes_out_reg, minutes_out_next;

    // Combinational helpers.
    logic                   in_accept;
    logic                   out_load;
    logic [CMP_W-1:0]       samp_ext;
    logic [SAMPLE_BITS-1:0] divisor;
    logic [SAMPLE_BITS:0]   shifted;
    logic                   quo_bit;
    logic [NUM_W-1:0]       quo_step;
    logic [DUTY_W-1:0]      quo_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign samp_ext  = CMP_W'(sample);
    // The divisor full scale minus sample is the bitwise complement of the sample.
    assign divisor   = ~sample;
    // In the load state, the output register takes a new item when it is empty or being emptied.
    assign out_load  = (state_reg == ST_LOAD) && (!out_valid_reg || !out_stall);

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        quo_bit  = (shifted >= {1'b0, dvs_reg});
        quo_step = {quo_reg[NUM_W-2:0], quo_bit};
        if (|quo_step[NUM_W-1:DUTY_W])
        begin
            quo_sat = DUTY_MAX;
        end
        else
        begin
            quo_sat = quo_step[DUTY_W-1:0];
        end
    end

    // Next-state logic for configuration, charge state, divider and output register.
    always_comb
    begin
        low_thr_next      = low_thr_reg;
        high_thr_next     = high_thr_reg;
        max_thr_next      = max_thr_reg;
        trickle_next      = trickle_reg;
        normal_next       = normal_reg;
        min_limit_next    = min_limit_reg;
        state_next        = state_reg;
        duty_next         = duty_reg;
        prev_sample_next  = prev_sample_reg;
        stage_next        = stage_reg;
        led_next          = led_reg;
        minute_count_next = minute_count_reg;
        status_next       = status_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        dvs_next          = dvs_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        duty_out_next     = duty_out_reg;
        stage_out_next    = stage_out_reg;
        led_out_next      = led_out_reg;
        status_out_next   = status_out_reg;
        minutes_out_next  = minutes_out_reg;

        // Register writes; indexes past the list are ignored.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LOW_THR:   low_thr_next   = cfg_data[THR_W-1:0];
                CFG_HIGH_THR:  high_thr_next  = cfg_data[THR_W-1:0];
                CFG_MAX_THR:   max_thr_next   = cfg_data[THR_W-1:0];
                CFG_TRICKLE:   trickle_next   = cfg_data[NUM_W-1:0];
                CFG_NORMAL:    normal_next    = cfg_data[NUM_W-1:0];
                CFG_MIN_LIMIT: min_limit_next = cfg_data[LIMIT_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // Most items go straight to the output register.
                    state_next = ST_LOAD;
                    if (status_reg != RUN_CHARGING)
                    begin
                        // Frozen: the held state is repeated.
                    end
                    else if (cmd)
                    begin
                        led_next = ~led_reg | stage_reg;
                    end
                    else if (minute_count_reg >= min_limit_reg)
                    begin
                        status_next = RUN_LIMIT;
                    end
                    else if (samp_ext <= CMP_W'(low_thr_reg))
                    begin
                        // Trickle band.
                        stage_next        = 1'b0;
                        prev_sample_next  = sample;
                        minute_count_next = minute_count_reg + 1'b1;
                        if (divisor == '0)
                        begin
                            duty_next = DUTY_MAX;
                        end
                        else
                        begin
                            quo_next   = trickle_reg;
                            rem_next   = '0;
                            dvs_next   = divisor;
                            cnt_next   = CNT_LAST;
                            state_next = ST_DIV;
                        end
                    end
                    else if (samp_ext <= CMP_W'(high_thr_reg))
                    begin
                        // Normal band; an unchanged sample means the cell is full.
                        stage_next = 1'b1;
                        if (sample == prev_sample_reg)
                        begin
                            duty_next   = '0;
                            led_next    = 1'b0;
                            status_next = RUN_STOPPED;
                        end
                        else
                        begin
                            prev_sample_next  = sample;
                            minute_count_next = minute_count_reg + 1'b1;
                            if (divisor == '0)
                            begin
                                duty_next = DUTY_MAX;
                            end
                            else
                            begin
                                quo_next   = normal_reg;
                                rem_next   = '0;
                                dvs_next   = divisor;
                                cnt_next   = CNT_LAST;
                                state_next = ST_DIV;
                            end
                        end
                    end
                    else if (samp_ext <= CMP_W'(max_thr_reg))
                    begin
                        // Stop band.
                        duty_next   = '0;
                        led_next    = 1'b0;
                        status_next = RUN_STOPPED;
                    end
                    else
                    begin
                        // Above max: duty and stage held, the minute still counts.
                        prev_sample_next  = sample;
                        minute_count_next = minute_count_reg + 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                if (quo_bit)
                begin
                    rem_next = SAMPLE_BITS'(shifted - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_next = shifted[SAMPLE_BITS-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    duty_next  = quo_sat;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    duty_out_next    = duty_reg;
                    stage_out_next   = stage_reg;
                    led_out_next     = led_reg;
                    status_out_next  = status_reg;
                    minutes_out_next = minute_count_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg      <= LOW_THR_RST;
            high_thr_reg     <= HIGH_THR_RST;
            max_thr_reg      <= MAX_THR_RST;
            trickle_reg      <= TRICKLE_RST;
            normal_reg       <= NORMAL_RST;
            min_limit_reg    <= MIN_LIMIT_RST;
            state_reg        <= ST_IDLE;
            duty_reg         <= '0;
            prev_sample_reg  <= '0;
            stage_reg        <= 1'b0;
            led_reg          <= 1'b0;
            minute_count_reg <= '0;
            status_reg       <= RUN_CHARGING;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            low_thr_reg      <= low_thr_next;
            high_thr_reg     <= high_thr_next;
            max_thr_reg      <= max_thr_next;
            trickle_reg      <= trickle_next;
            normal_reg       <= normal_next;
            min_limit_reg    <= min_limit_next;
            state_reg        <= state_next;
            duty_reg         <= duty_next;
            prev_sample_reg  <= prev_sample_next;
            stage_reg        <= stage_next;
            led_reg          <= led_next;
            minute_count_reg <= minute_count_next;
            status_reg       <= status_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Divider datapath and output payload carry no reset.
    always_ff @(posedge clk)
    begin
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        dvs_reg         <= dvs_next;
        duty_out_reg    <= duty_out_next;
        stage_out_reg   <= stage_out_next;
        led_out_reg     <= led_out_next;
        status_out_reg  <= status_out_next;
        minutes_out_reg <= minutes_out_next;
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign duty           = duty_out_reg;
    assign duty_high_byte = duty_out_reg[DUTY_W-1:2];
    assign duty_low_byte  = {duty_out_reg[1:0], {(BYTE_W-2){1'b0}}};
    assign charge_stage   = stage_out_reg;
    assign led_on         = led_out_reg;
    assign run_status     = status_out_reg;
    assign minutes_done   = minutes_out_reg;

    // The last division step always hands over to the output load.
    `NCD_ASSERT_NEXT(a_div_ends, (state_reg == ST_DIV) && (cnt_reg == '0), state_reg == ST_LOAD)
    // The partial remainder stays below the divisor throughout the division.
    `NCD_ASSERT_NOW(a_rem_below_dvs, state_reg == ST_DIV, rem_reg < dvs_reg)
    // A new item appears on the output only from the load state.
    `NCD_ASSERT_NOW(a_out_from_load, $rose(out_valid_reg), $past(state_reg) == ST_LOAD)
    // Once stopped or timed out, the status never changes again.
    `NCD_ASSERT_NEXT(a_frozen, status_reg != RUN_CHARGING, $stable(status_reg))
    // The minute count changes only while idle, when a sample is accepted.
    `NCD_ASSERT_NEXT(a_count_step, state_reg != ST_IDLE, $stable(minute_count_reg))

endmodule
`default_nettype wire
